// ===== src/read_coverage_accumulator_assert.svh =====
// ----------------------------------------------------------------------------
// Read coverage accumulator assertion macros
// Concurrent assertion wrappers; define ASSERT_OFF to compile them away.
// ----------------------------------------------------------------------------
`ifndef READ_COVERAGE_ACCUMULATOR_ASSERT_SVH
`define READ_COVERAGE_ACCUMULATOR_ASSERT_SVH
`ifndef ASSERT_OFF
// Check a condition at every clock edge outside reset.
`define RCA_ASSERT(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);
// Check that a trigger is followed by a condition in the next cycle.
`define RCA_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);
`else
`define RCA_ASSERT(label, clk, rst_n, prop, msg)
`define RCA_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg)
`endif
`endif

// ===== src/rca_pkg.sv =====
// ----------------------------------------------------------------------------
// Read coverage accumulator package
// Transfer types, opcodes, field widths and parameter defaults.
// ----------------------------------------------------------------------------
package rca_pkg;

    // Default sizing
    localparam int RCA_NUM_REFS    = 8;
    localparam int RCA_MAX_POS     = 4096;
    localparam int RCA_MAX_READ    = 512;
    localparam int RCA_COUNT_WIDTH = 16;

    // Fixed field widths
    localparam int OPCODE_W  = 2;
    localparam int REF_W     = 3;
    localparam int HLEN_W    = 20;
    localparam int START_W   = 20;
    localparam int RLEN_W    = 10;
    localparam int QPOS_W    = 12;
    localparam int DEPTH_W   = 16;

    typedef enum logic [OPCODE_W-1:0] {
        OP_HEADER = 2'd0,
        OP_ALIGN  = 2'd1,
        OP_QUERY  = 2'd2
    } rca_op_t;

    typedef struct packed {
        logic [OPCODE_W-1:0] opcode;
        logic [REF_W-1:0]    ref_index;
        logic                mapped;
        logic [HLEN_W-1:0]   ref_length;
        logic [START_W-1:0]  start_position;
        logic [RLEN_W-1:0]   read_length;
        logic [QPOS_W-1:0]   query_position;
    } rca_item_t;

    typedef struct packed {
        logic [DEPTH_W-1:0] depth;
        logic               in_range;
    } rca_result_t;

    // Result handed from the sequencer to the output register
    typedef struct packed {
        logic        load;
        rca_result_t data;
    } rca_res_t;

    // Sequencer status
    typedef struct packed {
        logic ready;
        logic clearing;
        logic q_pending;
    } rca_status_t;

endpackage

// ===== src/rca_ram.sv =====
// ----------------------------------------------------------------------------
// Generic simple dual-port RAM
// One write port, one read port, registered read data held between reads.
// ----------------------------------------------------------------------------
module rca_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 1024,
    localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic             re,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

// ===== src/rca_len_table.sv =====
// ----------------------------------------------------------------------------
// Reference length table
// Per-reference length, raised to the largest clamped header value seen.
// ----------------------------------------------------------------------------
module rca_len_table
    import rca_pkg::*;
#(
    parameter int NUM_REFS = RCA_NUM_REFS,
    parameter int MAX_POS  = RCA_MAX_POS,
    localparam int LEN_W   = $clog2(MAX_POS + 1)
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              upd,
    input  logic [REF_W-1:0]  idx,
    input  logic [HLEN_W-1:0] new_len,
    output logic [LEN_W-1:0]  len
);

    localparam int RIDX_W = (NUM_REFS > 1) ? $clog2(NUM_REFS) : 1;

    logic [LEN_W-1:0]  len_reg [NUM_REFS];
    logic              ref_ok;
    logic [RIDX_W-1:0] sel;
    logic [LEN_W-1:0]  clamped;

    assign ref_ok  = idx < NUM_REFS;
    assign sel     = RIDX_W'(idx);
    assign clamped = ({1'b0, new_len} > (HLEN_W + 1)'(MAX_POS)) ? LEN_W'(MAX_POS)
                                                                 : LEN_W'(new_len);
    assign len     = ref_ok ? len_reg[sel] : '0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < NUM_REFS; i++)
            begin
                len_reg[i] <= '0;
            end
        end
        else if (upd && ref_ok && (clamped > len_reg[sel]))
        begin
            len_reg[sel] <= clamped;
        end
    end

endmodule

// ===== src/rca_ctrl.sv =====
// ----------------------------------------------------------------------------
// Read coverage sequencer
// Clears the depth store, walks alignments base by base with a
// read-modify-write pipeline, and reads depth for queries.
// ----------------------------------------------------------------------------
module rca_ctrl
    import rca_pkg::*;
#(
    parameter int NUM_REFS    = RCA_NUM_REFS,
    parameter int MAX_POS     = RCA_MAX_POS,
    parameter int MAX_READ    = RCA_MAX_READ,
    parameter int COUNT_WIDTH = RCA_COUNT_WIDTH,
    localparam int LEN_W      = $clog2(MAX_POS + 1),
    localparam int DEPTH      = NUM_REFS * MAX_POS,
    localparam int AW         = $clog2(DEPTH)
) (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   item_valid,
    input  rca_item_t              item,
    input  logic                   out_free,
    input  logic [LEN_W-1:0]       tbl_len,
    output logic                   hdr_upd,
    output rca_status_t            status,
    output rca_res_t               res,
    output logic                   mem_we,
    output logic [AW-1:0]          mem_waddr,
    output logic [COUNT_WIDTH-1:0] mem_wdata,
    output logic                   mem_re,
    output logic [AW-1:0]          mem_raddr,
    input  logic [COUNT_WIDTH-1:0] mem_rdata
);

    localparam int PW = $clog2(MAX_POS);
    localparam int GW = $clog2(MAX_READ + 1);
    localparam int SW = START_W + 1;

    typedef enum logic [3:0] {
        ST_CLEAR = 4'b0001,
        ST_IDLE  = 4'b0010,
        ST_WALK  = 4'b0100,
        ST_QDATA = 4'b1000
    } state_t;

    state_t             state_reg, state_next;
    logic [AW-1:0]      clr_addr_reg, clr_addr_next;
    logic               wr_valid_reg, wr_valid_next;
    logic [AW-1:0]      wr_addr_reg, wr_addr_next;
    logic [GW-1:0]      g_reg, g_next;
    logic [GW-1:0]      cnt_reg, cnt_next;
    logic [START_W-1:0] start_reg, start_next;
    logic [LEN_W-1:0]   len_reg, len_next;
    logic [AW-1:0]      base_reg, base_next;
    logic               q_hit_reg, q_hit_next;
    logic               q_inr_reg, q_inr_next;

    logic               ready;
    logic               accept;
    logic               ref_ok;
    logic [AW-1:0]      item_base;
    logic [GW-1:0]      rlen_eff;
    logic               q_in_pos;
    logic [AW-1:0]      q_addr;
    logic [SW-1:0]      one_based;
    logic [SW-1:0]      pos;
    logic               base_hit;
    logic [AW-1:0]      walk_addr;
    logic [GW-1:0]      g_inc;
    logic [DEPTH_W-1:0] depth_clamp;

    assign ready     = (state_reg == ST_IDLE) && !wr_valid_reg;
    assign accept    = item_valid && ready;
    assign ref_ok    = item.ref_index < NUM_REFS;
    assign item_base = AW'(item.ref_index) * AW'(MAX_POS);
    assign rlen_eff  = (item.read_length > MAX_READ) ? GW'(MAX_READ) : GW'(item.read_length);
    assign q_in_pos  = item.query_position < MAX_POS;
    assign q_addr    = item_base + AW'(PW'(item.query_position));

    // Base position of the current walk step; start zero makes the first base fall off
    assign one_based = SW'(start_reg) + SW'(g_reg);
    assign pos       = one_based - SW'(1);
    assign base_hit  = (one_based != '0) && (pos < SW'(len_reg));
    assign walk_addr = base_reg + AW'(pos[PW-1:0]);
    assign g_inc     = g_reg + GW'(1);

    assign hdr_upd   = accept && (item.opcode == OP_HEADER);

    generate
        if (COUNT_WIDTH > DEPTH_W)
        begin : g_wide_count
            assign depth_clamp = (|mem_rdata[COUNT_WIDTH-1:DEPTH_W]) ? '1
                                                                      : mem_rdata[DEPTH_W-1:0];
        end
        else
        begin : g_narrow_count
            assign depth_clamp = DEPTH_W'(mem_rdata);
        end
    endgenerate

    // Write port: clearing pass, or write-back of a saturating increment
    always_comb
    begin
        mem_we    = 1'b0;
        mem_waddr = wr_addr_reg;
        mem_wdata = (&mem_rdata) ? mem_rdata : mem_rdata + COUNT_WIDTH'(1);
        if (state_reg == ST_CLEAR)
        begin
            mem_we    = 1'b1;
            mem_waddr = clr_addr_reg;
            mem_wdata = '0;
        end
        else if (wr_valid_reg)
        begin
            mem_we = 1'b1;
        end
    end

    always_comb
    begin
        state_next        = state_reg;
        clr_addr_next     = clr_addr_reg;
        wr_valid_next     = 1'b0;
        wr_addr_next      = wr_addr_reg;
        g_next            = g_reg;
        cnt_next          = cnt_reg;
        start_next        = start_reg;
        len_next          = len_reg;
        base_next         = base_reg;
        q_hit_next        = q_hit_reg;
        q_inr_next        = q_inr_reg;
        mem_re            = 1'b0;
        mem_raddr         = walk_addr;
        res.load          = 1'b0;
        res.data.depth    = q_hit_reg ? depth_clamp : '0;
        res.data.in_range = q_inr_reg;

        unique case (state_reg)
            ST_CLEAR:
            begin
                clr_addr_next = clr_addr_reg + AW'(1);
                if (clr_addr_reg == AW'(DEPTH - 1))
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                if (accept)
                begin
                    unique case (rca_op_t'(item.opcode))
                        OP_ALIGN:
                        begin
                            if (ref_ok && item.mapped && (rlen_eff != '0))
                            begin
                                g_next     = '0;
                                cnt_next   = rlen_eff;
                                start_next = item.start_position;
                                len_next   = tbl_len;
                                base_next  = item_base;
                                state_next = ST_WALK;
                            end
                        end
                        OP_QUERY:
                        begin
                            mem_re     = ref_ok && q_in_pos;
                            mem_raddr  = q_addr;
                            q_hit_next = ref_ok && q_in_pos;
                            q_inr_next = ref_ok && (item.query_position < tbl_len);
                            state_next = ST_QDATA;
                        end
                        default:
                        begin
                            // header updates the length table; reserved code is dropped
                        end
                    endcase
                end
            end
            ST_WALK:
            begin
                mem_re        = base_hit;
                wr_valid_next = base_hit;
                wr_addr_next  = walk_addr;
                g_next        = g_inc;
                if (g_inc == cnt_reg)
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_QDATA:
            begin
                if (out_free)
                begin
                    res.load   = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_CLEAR;
            end
        endcase
    end

    assign status = '{
        ready:     ready,
        clearing:  (state_reg == ST_CLEAR),
        q_pending: (state_reg == ST_QDATA)
    };

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= ST_CLEAR;
            clr_addr_reg <= '0;
            wr_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            clr_addr_reg <= clr_addr_next;
            wr_valid_reg <= wr_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        wr_addr_reg <= wr_addr_next;
        g_reg       <= g_next;
        cnt_reg     <= cnt_next;
        start_reg   <= start_next;
        len_reg     <= len_next;
        base_reg    <= base_next;
        q_hit_reg   <= q_hit_next;
        q_inr_reg   <= q_inr_next;
    end

endmodule

// ===== src/read_coverage_accumulator.sv =====
// ----------------------------------------------------------------------------
// Read coverage accumulator
// Per-position read depth pileup with per-reference length table.
// ----------------------------------------------------------------------------
// After reset the block clears its depth store, one entry per cycle, for
// NUM_REFS * MAX_POS entries (32768 with the defaults) and holds item_stall
// high meanwhile. An alignment item walks min(read_length, MAX_READ) bases,
// one base per cycle, each base a read-modify-write of the depth RAM through
// its single read and single write port, and the next item waits until the
// last write-back has retired. A query waits for the result register while
// it is stalled. Opcode 3 and items for references at or beyond NUM_REFS are
// dropped, except that such a query still returns depth 0 and in_range 0.
`include "read_coverage_accumulator_assert.svh"

module read_coverage_accumulator
    import rca_pkg::*;
#(
    parameter int NUM_REFS    = RCA_NUM_REFS,
    parameter int MAX_POS     = RCA_MAX_POS,
    parameter int MAX_READ    = RCA_MAX_READ,
    parameter int COUNT_WIDTH = RCA_COUNT_WIDTH
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        item_valid,
    output logic        item_stall,
    input  rca_item_t   item,
    output logic        result_valid,
    input  logic        result_stall,
    output rca_result_t result
);

    localparam int LEN_W = $clog2(MAX_POS + 1);
    localparam int DEPTH = NUM_REFS * MAX_POS;
    localparam int AW    = $clog2(DEPTH);

    rca_status_t            status;
    rca_res_t               res;
    logic                   hdr_upd;
    logic [LEN_W-1:0]       tbl_len;
    logic                   mem_we;
    logic [AW-1:0]          mem_waddr;
    logic [COUNT_WIDTH-1:0] mem_wdata;
    logic                   mem_re;
    logic [AW-1:0]          mem_raddr;
    logic [COUNT_WIDTH-1:0] mem_rdata;
    logic                   out_free;
    logic                   result_valid_reg;
    rca_result_t            result_reg;

    // Reference lengths live in flops; they are read at the item's index only.
    rca_len_table #(
        .NUM_REFS (NUM_REFS),
        .MAX_POS  (MAX_POS)
    ) u_len_table (
        .clk     (clk),
        .rst_n   (rst_n),
        .upd     (hdr_upd),
        .idx     (item.ref_index),
        .new_len (item.ref_length),
        .len     (tbl_len)
    );

    // Depth store: one entry per reference and position, addressed
    // ref_index * MAX_POS + position.
    rca_ram #(
        .WIDTH (COUNT_WIDTH),
        .DEPTH (DEPTH)
    ) u_depth_ram (
        .clk   (clk),
        .we    (mem_we),
        .waddr (mem_waddr),
        .wdata (mem_wdata),
        .re    (mem_re),
        .raddr (mem_raddr),
        .rdata (mem_rdata)
    );

    // The sequencer issues reads, writes back incremented counts in the next
    // cycle and holds off new items until that write has landed, so a read
    // never sees a stale count.
    rca_ctrl #(
        .NUM_REFS    (NUM_REFS),
        .MAX_POS     (MAX_POS),
        .MAX_READ    (MAX_READ),
        .COUNT_WIDTH (COUNT_WIDTH)
    ) u_ctrl (
        .clk        (clk),
        .rst_n      (rst_n),
        .item_valid (item_valid),
        .item       (item),
        .out_free   (out_free),
        .tbl_len    (tbl_len),
        .hdr_upd    (hdr_upd),
        .status     (status),
        .res        (res),
        .mem_we     (mem_we),
        .mem_waddr  (mem_waddr),
        .mem_wdata  (mem_wdata),
        .mem_re     (mem_re),
        .mem_raddr  (mem_raddr),
        .mem_rdata  (mem_rdata)
    );

    assign item_stall = !status.ready;

    // Output register: the slot frees in the same cycle its transfer completes,
    // so a waiting query result can load straight behind it.
    assign out_free = !result_valid_reg || !result_stall;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            result_valid_reg <= 1'b0;
        end
        else if (res.load)
        begin
            result_valid_reg <= 1'b1;
        end
        else if (!result_stall)
        begin
            result_valid_reg <= 1'b0;
        end
    end

    // Hold the payload until a new result loads.
    always_ff @(posedge clk)
    begin
        if (res.load)
        begin
            result_reg <= res.data;
        end
    end

    assign result_valid = result_valid_reg;
    assign result       = result_reg;

    // A result loads only into a free output slot.
    `RCA_ASSERT(a_load_free, clk, rst_n, !res.load || out_free, "result loaded over a held result")
    // No item is taken while the clearing pass runs.
    `RCA_ASSERT(a_clear_stall, clk, rst_n, !status.clearing || item_stall, "item taken during clear")
    // An accepted query always waits for its depth read.
    `RCA_ASSERT_NEXT(a_query_wait, clk, rst_n, item_valid && !item_stall && item.opcode == OP_QUERY, status.q_pending, "query not pending after transfer")
    // A loaded result shows up as valid in the next cycle.
    `RCA_ASSERT_NEXT(a_result_shown, clk, rst_n, res.load, result_valid, "loaded result not presented")

endmodule
